FILE: rtl/mqe_pkg.sv
package mqe_pkg;

    localparam int PORT_W      = 8;
    localparam int MASK_SLOTS  = 3;
    localparam int PERIOD_W    = 10;
    localparam int SPEED_SCALE = 1000;
    localparam int QUOT_W      = 10;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int DIV_CNT_W   = 4;
    localparam int ROT_W       = 32;
    localparam int SPEED_W     = 32;
    localparam int PROD_W      = ROT_W + QUOT_W;

    localparam logic signed [ROT_W-1:0] ROT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ROT_W-1:0] ROT_MIN = 32'sh8000_0000;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        REG_IN_USE = 3'd0,
        REG_ENC0_A = 3'd1,
        REG_ENC0_B = 3'd2,
        REG_ENC1_A = 3'd3,
        REG_ENC1_B = 3'd4,
        REG_ENC2_A = 3'd5,
        REG_ENC2_B = 3'd6,
        REG_PERIOD = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [1:0]                          in_use;
        logic [MASK_SLOTS-1:0][PORT_W-1:0]   a_mask;
        logic [MASK_SLOTS-1:0][PORT_W-1:0]   b_mask;
        logic [PERIOD_W-1:0]                 period;
    } cfg_t;

    typedef struct packed {
        logic load_event;
        logic load_tick;
        logic div_step;
        logic mul_step;
        logic emit_event;
        logic emit_tick;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_index_ok;
        logic hits_pending;
        logic out_free;
    } ctrl_status_t;

    // indexed [new phase][previous phase]
    localparam logic signed [1:0] STEP_TABLE [4][4] = '{
        '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0}
    };

endpackage

FILE: rtl/mqe_regs.sv
module mqe_regs
    import mqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    reg_index_t wr_index;
    logic       wr_en;

    assign wr_index = reg_index_t'(paddr[4:2]);
    assign wr_en    = psel & penable & pwrite;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_use <= '0;
            cfg_reg.a_mask <= '0;
            cfg_reg.b_mask <= '0;
            cfg_reg.period <= PERIOD_W'(10);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IN_USE: cfg_reg.in_use    <= pwdata[1:0];
                REG_ENC0_A: cfg_reg.a_mask[0] <= pwdata[PORT_W-1:0];
                REG_ENC0_B: cfg_reg.b_mask[0] <= pwdata[PORT_W-1:0];
                REG_ENC1_A: cfg_reg.a_mask[1] <= pwdata[PORT_W-1:0];
                REG_ENC1_B: cfg_reg.b_mask[1] <= pwdata[PORT_W-1:0];
                REG_ENC2_A: cfg_reg.a_mask[2] <= pwdata[PORT_W-1:0];
                REG_ENC2_B: cfg_reg.b_mask[2] <= pwdata[PORT_W-1:0];
                REG_PERIOD: cfg_reg.period    <= pwdata[PERIOD_W-1:0];
                default:    cfg_reg.in_use    <= cfg_reg.in_use;
            endcase
        end
    end

    always_comb
    begin
        case (wr_index)
            REG_IN_USE: prdata = 32'(cfg_reg.in_use);
            REG_ENC0_A: prdata = 32'(cfg_reg.a_mask[0]);
            REG_ENC0_B: prdata = 32'(cfg_reg.b_mask[0]);
            REG_ENC1_A: prdata = 32'(cfg_reg.a_mask[1]);
            REG_ENC1_B: prdata = 32'(cfg_reg.b_mask[1]);
            REG_ENC2_A: prdata = 32'(cfg_reg.a_mask[2]);
            REG_ENC2_B: prdata = 32'(cfg_reg.b_mask[2]);
            REG_PERIOD: prdata = 32'(cfg_reg.period);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/mqe_ctrl.sv
module mqe_ctrl
    import mqe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         command,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EVENT    = 5'b00010,
        S_DIV      = 5'b00100,
        S_MUL      = 5'b01000,
        S_TICK_OUT = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_code_t'(command) == CMD_EVENT)
                    begin
                        cmd.load_event = 1'b1;
                        state_next     = S_EVENT;
                    end
                    else if (status.tick_index_ok)
                    begin
                        cmd.load_tick = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_EVENT:
            begin
                if (!status.hits_pending)
                    state_next = S_IDLE;
                else if (status.out_free)
                    cmd.emit_event = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_TICK_OUT;
            end
            S_TICK_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_tick = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/mqe_dp.sv
module mqe_dp
    import mqe_pkg::*;
#(
    parameter int ENCODER_SLOTS  = 3,
    parameter int STEPS_PER_TURN = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  ctrl_cmd_t                cmd,
    output ctrl_status_t             status,
    input  logic [PORT_W-1:0]        trigger_pins,
    input  logic [PORT_W-1:0]        port_state,
    input  logic [1:0]               encoder_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               which_encoder,
    output logic signed [ROT_W-1:0]  rotation_count,
    output logic [SPEED_W-1:0]       speed_value,
    output logic                     last
);

    localparam int SLOT_W = (ENCODER_SLOTS > 1) ? $clog2(ENCODER_SLOTS) : 1;
    localparam int STEP_W = $clog2(STEPS_PER_TURN) + 2;
    localparam logic signed [STEP_W-1:0] STEP_LIM = STEP_W'(STEPS_PER_TURN);

    // per-slot encoder state
    logic [1:0]               prev_phase_reg [ENCODER_SLOTS];
    logic signed [STEP_W-1:0] step_reg       [ENCODER_SLOTS];
    logic signed [ROT_W-1:0]  rot_reg        [ENCODER_SLOTS];
    logic signed [ROT_W-1:0]  rot_tick_reg   [ENCODER_SLOTS];
    logic [SPEED_W-1:0]       speed_reg      [ENCODER_SLOTS];

    logic [ENCODER_SLOTS-1:0] hit_reg, hit_next;
    logic [PORT_W-1:0]        port_reg;
    logic [SLOT_W-1:0]        tick_slot_reg;
    logic signed [ROT_W:0]    delta_reg;
    logic [ROT_W-1:0]         abs_reg;
    logic [QUOT_W-1:0]        num_reg;
    logic [PERIOD_W-1:0]      rem_reg;
    logic [PERIOD_W-1:0]      divisor_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     out_valid_reg;

    logic [SLOT_W-1:0]        tick_slot;
    logic [SLOT_W-1:0]        sel;
    logic [ENCODER_SLOTS-1:0] sel_onehot;
    logic                     sel_last;
    logic [1:0]               phase;
    logic signed [STEP_W-1:0] step_sum;
    logic signed [STEP_W-1:0] step_new;
    logic signed [ROT_W-1:0]  rot_new;
    logic [PERIOD_W:0]        trial;
    logic                     trial_ge;
    logic [PERIOD_W:0]        trial_diff;
    logic [SPEED_W-1:0]       speed_sat;

    assign tick_slot = encoder_index[SLOT_W-1:0];

    // encoders hit by this event, limited to the enabled slots
    always_comb
    begin
        for (int i = 0; i < ENCODER_SLOTS; i++)
        begin
            hit_next[i] = (2'(i) < cfg.in_use) &&
                          ((trigger_pins & (cfg.a_mask[i] | cfg.b_mask[i])) != '0);
        end
    end

    // lowest pending slot
    always_comb
    begin
        sel        = '0;
        sel_onehot = '0;
        for (int i = ENCODER_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                sel        = SLOT_W'(i);
                sel_onehot = '0;
                sel_onehot[i] = 1'b1;
            end
        end
        sel_last = ((hit_reg & ~sel_onehot) == '0);
    end

    always_comb
    begin
        phase[0] = (port_reg & cfg.a_mask[sel]) != '0;
        phase[1] = (port_reg & cfg.b_mask[sel]) != '0;
        step_sum = step_reg[sel] + STEP_W'(STEP_TABLE[phase][prev_phase_reg[sel]]);
        step_new = step_sum;
        rot_new  = rot_reg[sel];
        if (step_sum >= STEP_LIM)
        begin
            step_new = '0;
            if (rot_reg[sel] != ROT_MAX)
                rot_new = rot_reg[sel] + 1;
        end
        else if (step_sum <= -STEP_LIM)
        begin
            step_new = '0;
            if (rot_reg[sel] != ROT_MIN)
                rot_new = rot_reg[sel] - 1;
        end
    end

    // restoring divider for scale / period, one quotient bit a step
    assign trial      = {rem_reg, num_reg[QUOT_W-1]};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign speed_sat = (prod_reg[PROD_W-1:SPEED_W] != '0) ? '1 : prod_reg[SPEED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENCODER_SLOTS; i++)
            begin
                prev_phase_reg[i] <= '0;
                step_reg[i]       <= '0;
                rot_reg[i]        <= '0;
                rot_tick_reg[i]   <= '0;
                speed_reg[i]      <= '0;
            end
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.load_event)
                hit_reg <= hit_next;
            if (cmd.emit_event)
            begin
                prev_phase_reg[sel] <= phase;
                step_reg[sel]       <= step_new;
                rot_reg[sel]        <= rot_new;
                hit_reg             <= hit_reg & ~sel_onehot;
                out_valid_reg       <= 1'b1;
            end
            if (cmd.emit_tick)
            begin
                rot_tick_reg[tick_slot_reg] <= rot_reg[tick_slot_reg];
                speed_reg[tick_slot_reg]    <= speed_sat;
                out_valid_reg               <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_event)
            port_reg <= port_state;
        if (cmd.load_tick)
        begin
            tick_slot_reg <= tick_slot;
            delta_reg     <= (ROT_W+1)'(rot_reg[tick_slot]) -
                             (ROT_W+1)'(rot_tick_reg[tick_slot]);
            num_reg       <= QUOT_W'(SPEED_SCALE);
            rem_reg       <= '0;
            divisor_reg   <= (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
        end
        if (cmd.div_step)
        begin
            abs_reg <= delta_reg[ROT_W] ? ROT_W'(-delta_reg) : delta_reg[ROT_W-1:0];
            rem_reg <= trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            num_reg <= {num_reg[QUOT_W-2:0], trial_ge};
        end
        if (cmd.mul_step)
            prod_reg <= abs_reg * num_reg;
        if (cmd.emit_event)
        begin
            which_encoder  <= 2'(sel);
            rotation_count <= rot_new;
            speed_value    <= speed_reg[sel];
            last           <= sel_last;
        end
        if (cmd.emit_tick)
        begin
            which_encoder  <= 2'(tick_slot_reg);
            rotation_count <= rot_reg[tick_slot_reg];
            speed_value    <= speed_sat;
            last           <= 1'b1;
        end
    end

    assign out_valid            = out_valid_reg;
    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.hits_pending  = (hit_reg != '0);
    assign status.tick_index_ok = (encoder_index < 2'(ENCODER_SLOTS));

endmodule

FILE: rtl/multi_quadrature_encoder_counter.sv
// channel   direction  handshake             fields
// in        input      in_valid / in_ready   command, trigger_pins, port_state, encoder_index
// out       output     out_valid / out_ready which_encoder, rotation_count, speed_value, last
// cfg       input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// an event emits one output word per decoded encoder, lowest slot first
// a tick runs in order: accept, the bit-serial divider of 1000 / period,
// multiply, then output
// one item at a time; in_ready is high only when the controller is idle
// reset clears all encoder state and the config registers; no clearing pass is needed
// a stalled output word holds the controller until out_ready frees it
module multi_quadrature_encoder_counter
    import mqe_pkg::*;
#(
    parameter int ENCODER_SLOTS  = 3,
    parameter int STEPS_PER_TURN = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [PORT_W-1:0]        trigger_pins,
    input  logic [PORT_W-1:0]        port_state,
    input  logic [1:0]               encoder_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               which_encoder,
    output logic signed [ROT_W-1:0]  rotation_count,
    output logic [SPEED_W-1:0]       speed_value,
    output logic                     last
);

    cfg_t         cfg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign pready = 1'b1;

    mqe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mqe_dp #(
        .ENCODER_SLOTS  (ENCODER_SLOTS),
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .trigger_pins   (trigger_pins),
        .port_state     (port_state),
        .encoder_index  (encoder_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .which_encoder  (which_encoder),
        .rotation_count (rotation_count),
        .speed_value    (speed_value),
        .last           (last)
    );

endmodule

FILE: tb/multi_quadrature_encoder_counter_tb.sv
module multi_quadrature_encoder_counter_tb;
    import mqe_pkg::*;

    localparam int SLOTS      = 3;
    localparam int TURN_STEPS = 8;
    localparam int STALL_MAX  = 4000;
    localparam int SETTLE     = 30;

    typedef struct packed {
        cmd_code_t  cmd;
        logic [7:0] trig;
        logic [7:0] port;
        logic [1:0] idx;
    } port_word_t;

    typedef struct packed {
        logic [1:0]        enc;
        logic signed [31:0] rot;
        logic [31:0]       spd;
        logic              last;
    } enc_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [7:0]  trigger_pins = '0;
    logic [7:0]  port_state = '0;
    logic [1:0]  encoder_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  which_encoder;
    logic signed [31:0] rotation_count;
    logic [31:0] speed_value;
    logic        last;

    // configuration copy held by the predictor
    logic [1:0]  cfg_in_use;
    logic [7:0]  cfg_a [SLOTS];
    logic [7:0]  cfg_b [SLOTS];
    logic [9:0]  cfg_period;

    // per encoder decoder state
    logic [1:0]         prev_phase [SLOTS];
    int                 step_cnt [SLOTS];
    logic signed [31:0] turns [SLOTS];
    logic signed [31:0] turns_at_tick [SLOTS];
    logic [31:0]        speed [SLOTS];

    port_word_t  pending_words [$];
    enc_report_t expected_reports [$];
    port_word_t  held_word;
    bit          word_held = 1'b0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    logic [7:0]  port_level = '0;

    multi_quadrature_encoder_counter #(
        .ENCODER_SLOTS  (SLOTS),
        .STEPS_PER_TURN (TURN_STEPS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .trigger_pins   (trigger_pins),
        .port_state     (port_state),
        .encoder_index  (encoder_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .which_encoder  (which_encoder),
        .rotation_count (rotation_count),
        .speed_value    (speed_value),
        .last           (last)
    );

    always #1 clk = ~clk;

    // gray order forward is 0 -> 1 -> 3 -> 2 -> 0
    function automatic logic [1:0] next_phase(logic [1:0] p, bit fwd);
        logic [1:0] n;
        if (fwd)
        begin
            case (p)
                2'd0: n = 2'd1;
                2'd1: n = 2'd3;
                2'd3: n = 2'd2;
                default: n = 2'd0;
            endcase
        end
        else
        begin
            case (p)
                2'd1: n = 2'd0;
                2'd3: n = 2'd1;
                2'd2: n = 2'd3;
                default: n = 2'd2;
            endcase
        end
        return n;
    endfunction

    function automatic int step_of(logic [1:0] new_p, logic [1:0] old_p);
        int s;
        if (next_phase(old_p, 1'b1) == new_p)
            s = 1;
        else if (next_phase(old_p, 1'b0) == new_p)
            s = -1;
        else
            s = 0;
        return s;
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void decode_word(port_word_t w);
        int          n;
        int          hits [$];
        logic [1:0]  ph;
        int unsigned per;
        longint      delta;
        longint      prod;
        enc_report_t r;
        if (w.cmd == CMD_TICK)
        begin
            if (w.idx >= SLOTS)
                return;
            per = (cfg_period == 0) ? 1 : cfg_period;
            delta = longint'(turns[w.idx]) - longint'(turns_at_tick[w.idx]);
            turns_at_tick[w.idx] = turns[w.idx];
            if (delta < 0)
                delta = -delta;
            prod = delta * longint'(SPEED_SCALE / per);
            speed[w.idx] = (prod > 64'shFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            r = '{enc: w.idx, rot: turns[w.idx], spd: speed[w.idx], last: 1'b1};
            expected_reports.push_back(r);
            return;
        end
        n = (cfg_in_use > SLOTS) ? SLOTS : cfg_in_use;
        for (int i = 0; i < n; i++)
        begin
            if ((w.trig & (cfg_a[i] | cfg_b[i])) == 0)
                continue;
            ph = {|(w.port & cfg_b[i]), |(w.port & cfg_a[i])};
            step_cnt[i] += step_of(ph, prev_phase[i]);
            prev_phase[i] = ph;
            if (step_cnt[i] >= TURN_STEPS)
            begin
                step_cnt[i] = 0;
                if (turns[i] != ROT_MAX)
                    turns[i] = turns[i] + 1;
            end
            if (step_cnt[i] <= -TURN_STEPS)
            begin
                step_cnt[i] = 0;
                if (turns[i] != ROT_MIN)
                    turns[i] = turns[i] - 1;
            end
            hits.push_back(i);
        end
        foreach (hits[k])
        begin
            r = '{enc: hits[k][1:0], rot: turns[hits[k]], spd: speed[hits[k]],
                  last: (k == hits.size() - 1)};
            expected_reports.push_back(r);
        end
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_word(held_word);
                word_held = 1'b0;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_word = pending_words.pop_front();
                    word_held = 1'b1;
                    command       <= held_word.cmd;
                    trigger_pins  <= held_word.trig;
                    port_state    <= held_word.port;
                    encoder_index <= held_word.idx;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        enc_report_t got;
        enc_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{enc: which_encoder, rot: rotation_count, spd: speed_value, last: last};
            if (expected_reports.size() == 0)
            begin
                flag_error($sformatf("unexpected word: enc %0d rot %0d speed %0d last %0b",
                                     got.enc, got.rot, got.spd, got.last));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.enc !== want.enc || got.rot !== want.rot ||
                    got.spd !== want.spd || got.last !== want.last)
                    flag_error($sformatf({"mismatch: expected enc %0d rot %0d speed %0d",
                                          " last %0b, got enc %0d rot %0d speed %0d last %0b"},
                                         want.enc, want.rot, want.spd, want.last,
                                         got.enc, got.rot, got.spd, got.last));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_index_t r, logic [31:0] v);
        logic [31:0] junk;
        logic [31:0] wd;
        junk = $urandom;
        case (r)
            REG_IN_USE: wd = {junk[31:2], v[1:0]};
            REG_PERIOD: wd = {junk[31:10], v[9:0]};
            default:    wd = {junk[31:8], v[7:0]};
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_IN_USE: cfg_in_use = v[1:0];
            REG_ENC0_A: cfg_a[0] = v[7:0];
            REG_ENC0_B: cfg_b[0] = v[7:0];
            REG_ENC1_A: cfg_a[1] = v[7:0];
            REG_ENC1_B: cfg_b[1] = v[7:0];
            REG_ENC2_A: cfg_a[2] = v[7:0];
            REG_ENC2_B: cfg_b[2] = v[7:0];
            REG_PERIOD: cfg_period = v[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] in_use, logic [7:0] a0, logic [7:0] b0,
                              logic [7:0] a1, logic [7:0] b1, logic [7:0] a2,
                              logic [7:0] b2, logic [9:0] period);
        write_reg(REG_IN_USE, in_use);
        write_reg(REG_ENC0_A, a0);
        write_reg(REG_ENC0_B, b0);
        write_reg(REG_ENC1_A, a1);
        write_reg(REG_ENC1_B, b1);
        write_reg(REG_ENC2_A, a2);
        write_reg(REG_ENC2_B, b2);
        write_reg(REG_PERIOD, period);
    endtask

    // waits until every queued word is taken and answered
    task automatic wait_drained();
        while (pending_words.size() != 0 || word_held || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_word(cmd_code_t cmd, logic [7:0] trig, logic [7:0] port,
                             logic [1:0] idx);
        port_word_t w;
        w = '{cmd: cmd, trig: trig, port: port, idx: idx};
        if (cmd == CMD_EVENT)
            port_level = port;
        pending_words.push_back(w);
    endtask

    // one quadrature edge of encoder e in the given direction
    task automatic push_step(int e, bit fwd);
        logic [1:0] p;
        logic [1:0] n;
        logic [7:0] lvl;
        logic [7:0] trig;
        p = {|(port_level & cfg_b[e]), |(port_level & cfg_a[e])};
        n = next_phase(p, fwd);
        lvl = n[0] ? (port_level | cfg_a[e]) : (port_level & ~cfg_a[e]);
        lvl = n[1] ? (lvl | cfg_b[e]) : (lvl & ~cfg_b[e]);
        trig = lvl ^ port_level;
        if ($urandom_range(9) == 0)
            trig = trig | 8'($urandom);
        push_word(CMD_EVENT, trig, lvl, 2'($urandom_range(3)));
    endtask

    task automatic run_random(int count);
        int  run_enc;
        bit  run_fwd;
        int  run_left;
        int  pick;
        run_enc = 0;
        run_fwd = 1'b1;
        run_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if (run_left == 0)
                begin
                    run_enc = $urandom_range(SLOTS - 1);
                    run_fwd = $urandom_range(1);
                    run_left = $urandom_range(1, 20);
                end
                push_step(run_enc, run_fwd);
                run_left--;
            end
            else if (pick < 85)
            begin
                push_word(CMD_TICK, 8'($urandom), 8'($urandom), 2'($urandom_range(3)));
            end
            else
            begin
                push_word(CMD_EVENT, 8'($urandom), 8'($urandom), 2'($urandom_range(3)));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        cfg_in_use = '0;
        cfg_period = 10'd10;
        for (int i = 0; i < SLOTS; i++)
        begin
            cfg_a[i] = '0;
            cfg_b[i] = '0;
            prev_phase[i] = '0;
            step_cnt[i] = 0;
            turns[i] = '0;
            turns_at_tick[i] = '0;
            speed[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: no encoder enabled, period 10
        send_idle_pct = 33;
        recv_idle_pct = 58;
        push_word(CMD_TICK, 8'h00, 8'h00, 2'd0);
        push_word(CMD_EVENT, 8'hFF, 8'h00, 2'd3);
        wait_drained();

        set_config(2'd3, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 10'd1);
        push_word(CMD_EVENT, 8'h00, 8'hFF, 2'd0);
        // full turn forward, then back on the next encoder
        for (int i = 0; i < TURN_STEPS; i++)
            push_step(0, 1'b1);
        push_word(CMD_TICK, 8'hFF, 8'hFF, 2'd0);
        for (int i = 0; i < TURN_STEPS; i++)
            push_step(1, 1'b0);
        push_word(CMD_TICK, 8'h00, 8'h00, 2'd1);
        push_word(CMD_TICK, 8'h00, 8'h00, 2'd3);
        push_word(CMD_TICK, 8'hFF, 8'h00, 2'd2);
        push_word(CMD_EVENT, 8'hFF, 8'hFF, 2'd0);
        push_word(CMD_EVENT, 8'hFF, 8'h00, 2'd2);
        wait_drained();

        run_random(21);

        // multi-bit masks, slot two disabled, zero period
        set_config(2'd2, 8'h03, 8'h0C, 8'h10, 8'h20, 8'($urandom), 8'($urandom), 10'd0);
        run_random(21);

        // slot two has empty masks, period at the top of the range
        send_idle_pct = 58;
        recv_idle_pct = 33;
        set_config(2'd3, 8'h80, 8'h40, 8'h01, 8'h02, 8'h00, 8'h00, 10'd1000);
        run_random(21);

        // one encoder in use, period beyond the range gives zero speed
        set_config(2'd1, 8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023);
        run_random(21);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(2'd3, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 10'($urandom_range(1, 1000)));
        run_random(21);

        set_config(2'd3, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 10'd7);
        run_random(21);

        if (expected_reports.size() != 0)
            flag_error($sformatf("%0d expected words never arrived",
                                 expected_reports.size()));
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mqe_pkg.sv
rtl/mqe_regs.sv
rtl/mqe_ctrl.sv
rtl/mqe_dp.sv
rtl/multi_quadrature_encoder_counter.sv
tb/multi_quadrature_encoder_counter_tb.sv
